FILE: rtl/see_pkg.sv
package see_pkg;

	// Datapath width and default stack depth.
	localparam int DATA_W       = 64;
	localparam int HALF_W       = DATA_W / 2;
	localparam int STACK_DEPTH  = 64;

	// Width of the step counter of the arithmetic unit: it counts up to the number of quotient bits.
	localparam int ALU_CNT_W    = $clog2(DATA_W + 1);
	localparam int MUL_STEPS    = 3;

	// Token kinds.
	localparam logic TOK_NUMBER   = 1'b0;
	localparam logic TOK_OPERATOR = 1'b1;

	// Operator codes.
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} see_op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_UNDERFLOW = 2'd1,
		STS_OVERFLOW  = 2'd2,
		STS_DIVZERO   = 2'd3
	} see_status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_EMIT
	} see_state_t;

	// One input transaction.
	typedef struct packed {
		logic                     token_kind;
		logic signed [DATA_W-1:0] token_value;
		logic [1:0]               operator_code;
		logic                     last_token;
	} see_in_t;

	// One output transaction.
	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic [1:0]               status;
	} see_out_t;

	// Per-cell shift control.
	typedef struct packed {
		logic load;
		logic push;
		logic pop;
	} see_cell_ctl_t;

	// Request to the multi-cycle arithmetic unit.
	typedef struct packed {
		logic              start;
		logic              is_div;
		logic [DATA_W-1:0] left;
		logic [DATA_W-1:0] right;
	} see_alu_req_t;

	// Status returned by the arithmetic unit.
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DATA_W-1:0] result;
	} see_alu_rsp_t;

endpackage

FILE: rtl/see_cell.sv
module see_cell (
	input  logic                         clk,
	input  see_pkg::see_cell_ctl_t       ctl,
	input  logic [see_pkg::DATA_W-1:0]   load_d,
	input  logic [see_pkg::DATA_W-1:0]   up_d,
	input  logic [see_pkg::DATA_W-1:0]   dn_d,
	output logic [see_pkg::DATA_W-1:0]   q
);

	logic [see_pkg::DATA_W-1:0] val_q;

	// One stack entry: loaded at the head, or shifted from a neighbour.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			val_q <= load_d;
		end else if (ctl.push) begin
			val_q <= up_d;
		end else if (ctl.pop) begin
			val_q <= dn_d;
		end
	end

	assign q = val_q;

endmodule

FILE: rtl/see_alu.sv
module see_alu (
	input  logic                  clk,
	input  logic                  arst_n,
	input  see_pkg::see_alu_req_t req,
	output see_pkg::see_alu_rsp_t rsp
);

	localparam int W = see_pkg::DATA_W;
	localparam int H = see_pkg::HALF_W;
	localparam int CW = see_pkg::ALU_CNT_W;

	logic          busy_q;
	logic          done_q;
	logic          is_div_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  result_q;

	logic [H-1:0]  mul_x;
	logic [H-1:0]  mul_y;
	logic [W-1:0]  prod;
	logic [W:0]    rem_sh;
	logic          rem_ge;
	logic [W-1:0]  left_mag;
	logic [W-1:0]  right_mag;

	// Magnitudes of the operands for the divider.
	assign left_mag  = req.left[W-1] ? (W'(0) - req.left) : req.left;
	assign right_mag = req.right[W-1] ? (W'(0) - req.right) : req.right;

	// One shared 32x32 multiplier, operand halves chosen by the step.
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin
				mul_x = a_q[H-1:0];
				mul_y = b_q[H-1:0];
			end
			2'd1: begin
				mul_x = a_q[H-1:0];
				mul_y = b_q[W-1:H];
			end
			default: begin
				mul_x = a_q[W-1:H];
				mul_y = b_q[H-1:0];
			end
		endcase
	end

	assign prod = mul_x * mul_y;

	// One restoring division step.
	assign rem_sh = {rem_q, quo_q[W-1]};
	assign rem_ge = (rem_sh >= {1'b0, b_q});

	// Sequencing of multiply (partial products) and divide (bit per cycle).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if ((is_div_q && cnt_q == CW'(W)) ||
				    (!is_div_q && cnt_q == CW'(see_pkg::MUL_STEPS))) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			is_div_q <= req.is_div;
			neg_q    <= req.left[W-1] ^ req.right[W-1];
			a_q      <= req.left;
			b_q      <= req.is_div ? right_mag : req.right;
			quo_q    <= left_mag;
			rem_q    <= '0;
		end else if (busy_q) begin
			if (is_div_q) begin
				if (cnt_q == CW'(W)) begin
					result_q <= neg_q ? (W'(0) - quo_q) : quo_q;
				end else begin
					rem_q <= rem_ge ? W'(rem_sh - {1'b0, b_q}) : rem_sh[W-1:0];
					quo_q <= {quo_q[W-2:0], rem_ge};
				end
			end else begin
				case (cnt_q[1:0])
					2'd0: acc_q <= prod;
					2'd1, 2'd2: acc_q <= acc_q + {prod[H-1:0], H'(0)};
					default: result_q <= acc_q;
				endcase
			end
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.result = result_q;

endmodule

FILE: rtl/stack_expression_evaluator.sv
// Number, add and subtract transactions are done in the idle state, without the arithmetic unit.
// Multiply uses the arithmetic unit (three 32x32 partial products on one multiplier).
// Divide uses the arithmetic unit (one quotient bit per cycle in the restoring divider).
// A last token moves the controller to the emit state; once the output is free, the result is registered and shown.
// Reset (arst_n low, asynchronous) empties the stack, clears the error and selects postfix mode.
module stack_expression_evaluator #(
	parameter int STACK_DEPTH = see_pkg::STACK_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  see_pkg::see_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output see_pkg::see_out_t out_data,
	input  logic             cfg_we,
	input  logic             cfg_wdata
);

	localparam int W    = see_pkg::DATA_W;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	see_pkg::see_state_t   state_q;
	see_pkg::see_state_t   state_d;
	logic [CNT_W-1:0]      cnt_q;
	see_pkg::see_status_t  err_q;
	logic                  prefix_q;
	logic                  last_q;
	logic                  out_valid_q;
	see_pkg::see_out_t     out_q;

	logic [W-1:0]          cell_q [STACK_DEPTH];
	see_pkg::see_cell_ctl_t cell_ctl [STACK_DEPTH];

	see_pkg::see_alu_req_t alu_req;
	see_pkg::see_alu_rsp_t alu_rsp;

	logic                  accept;
	logic                  out_free;
	logic                  tok_ok;
	logic                  do_push;
	logic                  do_pop;
	logic                  start_alu;
	logic                  emit_fire;
	logic [W-1:0]          left_v;
	logic [W-1:0]          right_v;
	logic [W-1:0]          addsub_v;
	logic [W-1:0]          head_d;
	see_pkg::see_status_t  err_set;
	logic                  err_hit;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign tok_ok   = accept && (err_q == see_pkg::STS_OK);

	// Operand order follows the evaluation mode.
	assign left_v   = prefix_q ? cell_q[0] : cell_q[1];
	assign right_v  = prefix_q ? cell_q[1] : cell_q[0];
	assign addsub_v = (see_pkg::see_op_t'(in_data.operator_code) == see_pkg::OP_ADD) ?
	                  (left_v + right_v) : (left_v - right_v);

	// Decode of an accepted token against the stack state, or of the arithmetic result while calculating.
	always_comb begin
		do_push   = 1'b0;
		do_pop    = 1'b0;
		start_alu = 1'b0;
		err_hit   = 1'b0;
		err_set   = see_pkg::STS_OK;
		head_d    = addsub_v;
		if (state_q == see_pkg::S_CALC) begin
			do_pop = alu_rsp.done;
			head_d = alu_rsp.result;
		end else if (tok_ok) begin
			if (in_data.token_kind == see_pkg::TOK_NUMBER) begin
				head_d = in_data.token_value;
				if (cnt_q >= CNT_W'(STACK_DEPTH)) begin
					err_hit = 1'b1;
					err_set = see_pkg::STS_OVERFLOW;
				end else begin
					do_push = 1'b1;
				end
			end else if (cnt_q < CNT_W'(2)) begin
				err_hit = 1'b1;
				err_set = see_pkg::STS_UNDERFLOW;
			end else begin
				case (see_pkg::see_op_t'(in_data.operator_code))
					see_pkg::OP_ADD, see_pkg::OP_SUB: do_pop = 1'b1;
					see_pkg::OP_MUL: start_alu = 1'b1;
					default: begin
						if (right_v == '0) begin
							err_hit = 1'b1;
							err_set = see_pkg::STS_DIVZERO;
						end else begin
							start_alu = 1'b1;
						end
					end
				endcase
			end
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			see_pkg::S_IDLE: begin
				if (start_alu) begin
					state_d = see_pkg::S_CALC;
				end else if (accept && in_data.last_token) begin
					state_d = see_pkg::S_EMIT;
				end
			end
			see_pkg::S_CALC: begin
				if (alu_rsp.done) begin
					state_d = last_q ? see_pkg::S_EMIT : see_pkg::S_IDLE;
				end
			end
			see_pkg::S_EMIT: begin
				if (out_free) begin
					state_d = see_pkg::S_IDLE;
				end
			end
			default: state_d = see_pkg::S_IDLE;
		endcase
	end

	// Output decode of the controller.
	always_comb begin
		in_ready  = 1'b0;
		emit_fire = 1'b0;
		case (state_q)
			see_pkg::S_IDLE: in_ready = 1'b1;
			see_pkg::S_EMIT: emit_fire = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= see_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Stack count, sticky error and mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			err_q    <= see_pkg::STS_OK;
			prefix_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				prefix_q <= cfg_wdata;
			end
			if (accept) begin
				last_q <= in_data.last_token;
			end
			if (emit_fire) begin
				cnt_q <= '0;
				err_q <= see_pkg::STS_OK;
			end else begin
				if (do_push) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else if (do_pop) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
				if (err_hit) begin
					err_q <= err_set;
				end
			end
		end
	end

	// Result register towards the consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			if (err_q != see_pkg::STS_OK) begin
				out_q.result_value <= '0;
				out_q.status       <= err_q;
			end else if (cnt_q == '0) begin
				out_q.result_value <= '0;
				out_q.status       <= see_pkg::STS_UNDERFLOW;
			end else begin
				out_q.result_value <= cell_q[0];
				out_q.status       <= see_pkg::STS_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Row of stack cells; the head takes new values, the others shift.
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign cell_ctl[i] = '{load: do_push || do_pop, push: 1'b0, pop: 1'b0};
			see_cell u_cell (
				.clk    (clk),
				.ctl    (cell_ctl[i]),
				.load_d (head_d),
				.up_d   (head_d),
				.dn_d   (cell_q[1]),
				.q      (cell_q[i])
			);
		end else if (i == STACK_DEPTH - 1) begin : g_tail
			assign cell_ctl[i] = '{load: 1'b0, push: do_push, pop: do_pop};
			see_cell u_cell (
				.clk    (clk),
				.ctl    (cell_ctl[i]),
				.load_d (head_d),
				.up_d   (cell_q[i-1]),
				.dn_d   (cell_q[i]),
				.q      (cell_q[i])
			);
		end else begin : g_body
			assign cell_ctl[i] = '{load: 1'b0, push: do_push, pop: do_pop};
			see_cell u_cell (
				.clk    (clk),
				.ctl    (cell_ctl[i]),
				.load_d (head_d),
				.up_d   (cell_q[i-1]),
				.dn_d   (cell_q[i+1]),
				.q      (cell_q[i])
			);
		end
	end

	// Multiply and divide unit.
	assign alu_req.start  = start_alu;
	assign alu_req.is_div = (see_pkg::see_op_t'(in_data.operator_code) == see_pkg::OP_DIV);
	assign alu_req.left   = left_v;
	assign alu_req.right  = right_v;

	see_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// The stack count never passes the depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	// No new transaction is taken while the arithmetic unit works.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !alu_rsp.busy)
		else $error("transaction accepted while arithmetic unit busy");

	// The arithmetic unit finishes only while the controller waits for it.
	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> state_q == see_pkg::S_CALC)
		else $error("arithmetic result outside calculation state");

	// Emitting a result empties the stack and clears the error.
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> (cnt_q == '0) && (err_q == see_pkg::STS_OK) && out_valid_q)
		else $error("stack not cleared after result");

endmodule
